// File: rtl/cfsu_pkg.sv
// ============================================================================
// cfsu_pkg - shared definitions for the call-frame stack unit
// Operation and error codes, field widths and frame layout constants.
// ============================================================================
package cfsu_pkg;

    localparam int CFSU_DEPTH = 1024;   // default number of frame memory words

    localparam int DATA_W  = 32;        // stack word width
    localparam int INDEX_W = 10;        // slot index / word count width
    localparam int FUNC_W  = 3;         // operation selector width
    localparam int ERR_W   = 3;         // error code width

    // Wide signed width for frame arithmetic: a 32-bit marker plus a count
    // and a pointer of up to 17 bits never leaves this range.
    localparam int CALC_W = 34;

    // Words a frame needs beyond its locals: return word and marker.
    localparam int FRAME_HDR  = 2;
    // Distance from the frame end back to the marker word.
    localparam int MARKER_OFS = 1;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_ALLOC = 3'd1,
        OP_FREE  = 3'd2,
        OP_GET   = 3'd3,
        OP_SET   = 3'd4,
        OP_BACK  = 3'd5
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_INDEX = 3'd1,
        ERR_ALLOC = 3'd2,
        ERR_FREE  = 3'd3,
        ERR_PUSH  = 3'd4,
        ERR_UNDER = 3'd5
    } err_t;

endpackage

// File: rtl/call_frame_stack_unit_core.sv
// ============================================================================
// call_frame_stack_unit_core - call-frame stack of a virtual machine
// Push, alloc, free, get, set and back over one frame word memory.
// ============================================================================
// The unit keeps a frame base pointer, a top pointer and DEPTH stack words in
// a synchronous memory. Each input beat carries one operation in s_axis_tuser
// and answers with exactly one output beat: the word read (get, back) or
// zero, an error code and the unfreed-locals warning. The unit takes no new
// beat until the item is done: the accept cycle issues the one memory read
// the operation needs (marker, local slot or caller marker) and the execute
// cycle checks, writes back and updates the pointers. A back that succeeds
// goes on to the ST_BACK2 state for the second read of the frame's return
// word. A finished result waits in the output register while the next beat
// is taken; if the previous result has not been taken when another one
// finishes, the unit holds it and stops accepting. After reset the unit
// sweeps the memory to zero, one word per cycle, and s_axis_tready stays low
// until the sweep is done.
// ============================================================================
module call_frame_stack_unit_core
    import cfsu_pkg::*;
#(
    parameter int DEPTH = CFSU_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [9:0] index, [41:10] value, [47:42] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_value
    output logic [3:0]  m_axis_tuser    // [2:0] error, [3] unfreed_warning
);

    localparam int AW = $clog2(DEPTH);      // memory address width
    localparam int PW = $clog2(DEPTH + 1);  // pointer width, holds DEPTH itself

    localparam logic signed [CALC_W-1:0] DEPTH_W = CALC_W'(DEPTH);
    localparam logic signed [CALC_W-1:0] HDR_W   = CALC_W'(FRAME_HDR);
    localparam logic signed [CALC_W-1:0] MOFS_W  = CALC_W'(MARKER_OFS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_BACK2,
        ST_HOLD
    } state_t;

    // Registers
    state_t              state_reg,   state_next;
    logic [AW-1:0]       clr_reg,     clr_next;
    logic [PW-1:0]       base_reg,    base_next;
    logic [PW-1:0]       top_reg,     top_next;
    op_t                 func_reg,    func_next;
    logic [INDEX_W-1:0]  idx_reg,     idx_next;
    logic [DATA_W-1:0]   val_reg,     val_next;
    logic [PW-1:0]       nb_reg,      nb_next;
    logic                warn_reg,    warn_next;
    logic [DATA_W-1:0]   hold_rd_reg, hold_rd_next;
    err_t                hold_err_reg, hold_err_next;
    logic                hold_warn_reg, hold_warn_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_rd_reg,    m_rd_next;
    err_t                m_err_reg,   m_err_next;
    logic                m_warn_reg,  m_warn_next;

    // Memory port
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    // Input fields
    logic [INDEX_W-1:0]  in_idx;
    logic [DATA_W-1:0]   in_val;

    // Frame arithmetic
    logic signed [CALC_W-1:0] base_w, top_w, idx_w, in_idx_w, mark_w;
    logic signed [CALC_W-1:0] keep_w, cnt_w, end_w, mpos_w, negc_w;
    logic signed [CALC_W-1:0] slot_w, in_slot_w, lim_w, nb_w;
    logic [PW-1:0]       top_m1, base_m1;
    logic                alloc_fit, in_frame, back_ok, keep_pos;

    // Result of the finishing cycle
    logic                fin, slot_free;
    logic [DATA_W-1:0]   res_rd;
    err_t                res_err;
    logic                res_warn;

    cfsu_frame_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_idx = s_axis_tdata[INDEX_W-1:0];
    assign in_val = s_axis_tdata[INDEX_W+DATA_W-1:INDEX_W];

    // Zero-extend pointers and counts, sign-extend the marker word.
    assign base_w   = {{(CALC_W-PW){1'b0}}, base_reg};
    assign top_w    = {{(CALC_W-PW){1'b0}}, top_reg};
    assign idx_w    = {{(CALC_W-INDEX_W){1'b0}}, idx_reg};
    assign in_idx_w = {{(CALC_W-INDEX_W){1'b0}}, in_idx};
    assign mark_w   = {{(CALC_W-DATA_W){mem_rdata[DATA_W-1]}}, mem_rdata};

    // Free: locals to keep after releasing idx words. Alloc shares the end
    // and marker computation with the free remainder.
    assign keep_w    = -(mark_w + idx_w);
    assign keep_pos  = !keep_w[CALC_W-1] && (keep_w != '0);
    assign cnt_w     = (func_reg == OP_ALLOC) ? idx_w : keep_w;
    assign end_w     = base_w + cnt_w + HDR_W;
    assign mpos_w    = end_w - MOFS_W;
    assign negc_w    = -cnt_w;
    assign alloc_fit = (end_w <= DEPTH_W);

    // Get / set bounds: the slot must sit below the marker.
    assign slot_w    = base_w + idx_w;
    assign in_slot_w = base_w + in_idx_w;
    assign lim_w     = slot_w + HDR_W;
    assign in_frame  = (lim_w <= top_w);

    // Back: caller base restored through the marker below the frame.
    assign nb_w    = base_w + mark_w - HDR_W;
    assign back_ok = (base_reg != '0) && !nb_w[CALC_W-1] && (nb_w < base_w);

    assign top_m1  = top_reg - 1'b1;
    assign base_m1 = base_reg - 1'b1;

    assign slot_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        base_next      = base_reg;
        top_next       = top_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        nb_next        = nb_reg;
        warn_next      = warn_reg;
        hold_rd_next   = hold_rd_reg;
        hold_err_next  = hold_err_reg;
        hold_warn_next = hold_warn_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_rd_next      = m_rd_reg;
        m_err_next     = m_err_reg;
        m_warn_next    = m_warn_reg;

        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        mem_raddr = base_reg[AW-1:0];

        fin      = 1'b0;
        res_rd   = '0;
        res_err  = ERR_OK;
        res_warn = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the memory to zero after reset.
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next  = op_t'(s_axis_tuser[FUNC_W-1:0]);
                    idx_next   = in_idx;
                    val_next   = in_val;
                    state_next = ST_EXEC;
                end
                // Issue the one read the operation needs.
                case (op_t'(s_axis_tuser[FUNC_W-1:0]))
                    OP_FREE: mem_raddr = top_m1[AW-1:0];
                    OP_GET:  mem_raddr = in_slot_w[AW-1:0];
                    OP_BACK: mem_raddr = base_m1[AW-1:0];
                    default: mem_raddr = base_reg[AW-1:0];
                endcase
            end

            ST_EXEC:
            begin
                fin = 1'b1;
                case (func_reg)
                    OP_PUSH:
                    begin
                        if (top_reg < PW'(DEPTH))
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = top_reg[AW-1:0];
                            mem_wdata = val_reg;
                            base_next = top_reg;
                        end
                        else
                        begin
                            res_err = ERR_PUSH;
                        end
                    end

                    OP_ALLOC:
                    begin
                        if (alloc_fit)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = mpos_w[AW-1:0];
                            mem_wdata = negc_w[DATA_W-1:0];
                            top_next  = end_w[PW-1:0];
                        end
                        else
                        begin
                            res_err = ERR_ALLOC;
                        end
                    end

                    OP_FREE:
                    begin
                        if (top_reg <= base_reg)
                        begin
                            // No locals: only a zero count passes.
                            if (idx_reg != '0)
                            begin
                                res_err = ERR_FREE;
                            end
                        end
                        else if (keep_w == '0)
                        begin
                            top_next = base_reg;
                        end
                        else if (keep_pos)
                        begin
                            // Re-allocate the remainder with a new marker.
                            if (alloc_fit)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = mpos_w[AW-1:0];
                                mem_wdata = negc_w[DATA_W-1:0];
                                top_next  = end_w[PW-1:0];
                            end
                            else
                            begin
                                res_err = ERR_ALLOC;
                            end
                        end
                        else
                        begin
                            res_err = ERR_FREE;
                        end
                    end

                    OP_GET:
                    begin
                        if (in_frame)
                        begin
                            res_rd = mem_rdata;
                        end
                        else
                        begin
                            res_err = ERR_INDEX;
                        end
                    end

                    OP_SET:
                    begin
                        if (in_frame)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = slot_w[AW-1:0];
                            mem_wdata = val_reg;
                        end
                        else
                        begin
                            res_err = ERR_INDEX;
                        end
                    end

                    OP_BACK:
                    begin
                        if (back_ok)
                        begin
                            // Hold the result; read the return word next.
                            fin        = 1'b0;
                            nb_next    = nb_w[PW-1:0];
                            warn_next  = (top_reg != base_reg);
                            mem_raddr  = base_reg[AW-1:0];
                            state_next = ST_BACK2;
                        end
                        else
                        begin
                            res_err = ERR_UNDER;
                        end
                    end

                    default:
                    begin
                        // Undefined selector: no state change, error-free answer.
                    end
                endcase
            end

            ST_BACK2:
            begin
                fin       = 1'b1;
                res_rd    = mem_rdata;
                res_warn  = warn_reg;
                top_next  = base_reg;
                base_next = nb_reg;
            end

            ST_HOLD:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_rd_next    = hold_rd_reg;
                    m_err_next   = hold_err_reg;
                    m_warn_next  = hold_warn_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Deliver the finished result, or park it while the last beat waits.
        if (fin)
        begin
            if (slot_free)
            begin
                m_valid_next = 1'b1;
                m_rd_next    = res_rd;
                m_err_next   = res_err;
                m_warn_next  = res_warn;
                state_next   = ST_IDLE;
            end
            else
            begin
                hold_rd_next   = res_rd;
                hold_err_next  = res_err;
                hold_warn_next = res_warn;
                state_next     = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            base_reg      <= '0;
            top_reg       <= '0;
            func_reg      <= OP_PUSH;
            idx_reg       <= '0;
            val_reg       <= '0;
            nb_reg        <= '0;
            warn_reg      <= 1'b0;
            hold_rd_reg   <= '0;
            hold_err_reg  <= ERR_OK;
            hold_warn_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_rd_reg      <= '0;
            m_err_reg     <= ERR_OK;
            m_warn_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            base_reg      <= base_next;
            top_reg       <= top_next;
            func_reg      <= func_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            nb_reg        <= nb_next;
            warn_reg      <= warn_next;
            hold_rd_reg   <= hold_rd_next;
            hold_err_reg  <= hold_err_next;
            hold_warn_reg <= hold_warn_next;
            m_valid_reg   <= m_valid_next;
            m_rd_reg      <= m_rd_next;
            m_err_reg     <= m_err_next;
            m_warn_reg    <= m_warn_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_rd_reg;
    assign m_axis_tuser  = {m_warn_reg, m_err_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Frame pointers stay ordered and inside the memory.
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (base_reg <= top_reg) && (top_reg <= PW'(DEPTH)))
        else $error("frame base above top or top beyond memory");

    // One item at a time: no beat is taken right after an accepted beat.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input beat taken while an item is in execution");

    // A failed operation returns no data word.
    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:0] != ERR_OK)) |-> (m_axis_tdata == '0))
        else $error("nonzero read value with an error code");

    // The unfreed warning only comes with a successful back.
    a_warn_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> (m_axis_tuser[2:0] == ERR_OK))
        else $error("unfreed warning with an error code");

endmodule

// File: rtl/cfsu_frame_ram.sv
// ============================================================================
// cfsu_frame_ram - frame word memory
// One write port and one read port; read data registered.
// ============================================================================
module cfsu_frame_ram
    import cfsu_pkg::*;
#(
    parameter int DEPTH = CFSU_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
